@@ design/tasc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Turret aim slew controller package
// Shared widths, item and configuration types, CORDIC arctangent table and
// angle helpers for the front end, queue and slew back end.
// ----------------------------------------------------------------------------
package tasc_pkg;

  // Angle and CORDIC sizing
  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 16;

  // Fixed field widths
  localparam int COORD_W   = 16;
  localparam int HOLD_W    = 16;
  localparam int EL_W      = 10;
  localparam int RATE_W    = 12;
  localparam int ARC_W     = 15;
  localparam int REST_W    = 16;
  localparam int OUT_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // CORDIC datapath: coordinate scaled by 2^16, plus growth headroom
  localparam int CORDIC_FRAC = 16;
  localparam int CORDIC_W    = COORD_W + CORDIC_FRAC + 3;
  localparam int ACC_W       = 32;
  localparam int RND_SHIFT   = ACC_W - ANGLE_BITS;

  // Offset and step arithmetic
  localparam int OFF_W  = (ANGLE_BITS + 2 > ARC_W + 2) ? ANGLE_BITS + 2 : ARC_W + 2;
  localparam int PROD_W = RATE_W + EL_W;
  localparam int SAT_W  = (ANGLE_BITS > PROD_W) ? ANGLE_BITS : PROD_W;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (ACC_W - 1);

  typedef logic [ANGLE_BITS-1:0]  angle_t;
  typedef logic signed [OFF_W-1:0] offset_t;

  typedef enum logic {
    OP_AIM  = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REST_BEARING  = 2'd0,
    CFG_ARC_HALF      = 2'd1,
    CFG_TRAVERSE_RATE = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [REST_W-1:0] rest_bearing;
    logic [ARC_W-1:0]         arc_half;
    logic [RATE_W-1:0]        traverse_rate;
  } tasc_cfg_t;

  // Classified item handed from the front end to the slew back end
  typedef struct packed {
    op_e               op;
    angle_t            goal;
    logic [HOLD_W-1:0] hold;
    logic [EL_W-1:0]   elapsed;
    angle_t            step;
  } tasc_item_t;

  // atan(2^-k) as a fraction of a turn, scaled by 2^32
  function automatic logic [ACC_W-1:0] atan_lut(input logic [4:0] k);
    logic [ACC_W-1:0] v;
    case (k)
      5'd0:    v = 32'h2000_0000;
      5'd1:    v = 32'h12E4_051E;
      5'd2:    v = 32'h09FB_385B;
      5'd3:    v = 32'h0511_11D4;
      5'd4:    v = 32'h028B_0D43;
      5'd5:    v = 32'h0145_D7E1;
      5'd6:    v = 32'h00A2_F61E;
      5'd7:    v = 32'h0051_7C55;
      5'd8:    v = 32'h0028_BE53;
      5'd9:    v = 32'h0014_5F2F;
      5'd10:   v = 32'h000A_2F98;
      5'd11:   v = 32'h0005_17CC;
      5'd12:   v = 32'h0002_8BE6;
      5'd13:   v = 32'h0001_45F3;
      5'd14:   v = 32'h0000_A2FA;
      5'd15:   v = 32'h0000_517D;
      5'd16:   v = 32'h0000_28BE;
      5'd17:   v = 32'h0000_145F;
      5'd18:   v = 32'h0000_0A30;
      5'd19:   v = 32'h0000_0518;
      5'd20:   v = 32'h0000_028C;
      5'd21:   v = 32'h0000_0146;
      5'd22:   v = 32'h0000_00A3;
      5'd23:   v = 32'h0000_0051;
      5'd24:   v = 32'h0000_0029;
      5'd25:   v = 32'h0000_0014;
      5'd26:   v = 32'h0000_000A;
      5'd27:   v = 32'h0000_0005;
      5'd28:   v = 32'h0000_0003;
      5'd29:   v = 32'h0000_0001;
      5'd30:   v = 32'h0000_0001;
      default: v = 32'h0000_0000;
    endcase
    return v;
  endfunction

  // Shortest signed turn from one bearing to another; exactly half a turn is positive
  function automatic offset_t shortest_turn(input angle_t from_a, input angle_t to_a);
    angle_t d;
    d = to_a - from_a;
    if (d == (angle_t'(1) << (ANGLE_BITS - 1))) begin
      return OFF_W'(d);
    end
    return OFF_W'(signed'(d));
  endfunction

  function automatic offset_t clamp_sym(input offset_t v, input offset_t lim);
    offset_t r;
    r = v;
    if (v > lim) begin
      r = lim;
    end else if (v < -lim) begin
      r = -lim;
    end
    return r;
  endfunction

  function automatic angle_t rest_angle(input logic signed [REST_W-1:0] rest);
    return ANGLE_BITS'(rest);
  endfunction

endpackage
`default_nettype wire

@@ design/tasc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Turret aim front end
// Accepts items, runs the pipelined CORDIC bearing for aim transactions,
// clamps the goal to the arc and saturates the tick step before queueing.
// ----------------------------------------------------------------------------
module tasc_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire tasc_pkg::tasc_cfg_t           cfg_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          operation_i,
  input  wire logic signed [15:0]            target_x_i,
  input  wire logic signed [15:0]            target_z_i,
  input  wire logic [tasc_pkg::HOLD_W-1:0]   hold_time_i,
  input  wire logic [tasc_pkg::EL_W-1:0]     elapsed_i,
  input  wire logic                          q_full_i,
  output logic                               push_o,
  output tasc_pkg::tasc_item_t               push_item_o
);
  import tasc_pkg::*;

  localparam int NS = CORDIC_STEPS;

  logic                       adv;
  logic [NS:0]                vld_q;
  logic signed [CORDIC_W-1:0] re_q   [NS+1];
  logic signed [CORDIC_W-1:0] im_q   [NS+1];
  logic [ACC_W-1:0]           acc_q  [NS+1];
  logic [NS:0]                org_q;
  op_e                        op_q   [NS+1];
  logic [HOLD_W-1:0]          hold_q [NS+1];
  logic [EL_W-1:0]            el_q   [NS+1];
  logic [PROD_W-1:0]          prod_q [NS+1];

  logic signed [CORDIC_W-1:0] re_nx  [NS];
  logic signed [CORDIC_W-1:0] im_nx  [NS];
  logic [ACC_W-1:0]           acc_nx [NS];

  logic signed [CORDIC_W-1:0] re_pre;
  logic signed [CORDIC_W-1:0] im_pre;
  logic [ACC_W-1:0]           acc_pre;
  logic                       org_pre;

  logic [ACC_W:0]             rounded;
  angle_t                     bearing;
  angle_t                     rest_a;
  offset_t                    off;
  offset_t                    lim;
  logic [SAT_W-1:0]           prod_w;
  logic [SAT_W-1:0]           half_w;
  tasc_item_t                 fin;

  logic                       tail_vld_q;
  tasc_item_t                 tail_q;

  // The whole pipe moves together; hold it only when the tail cannot drain
  assign adv         = !tail_vld_q || !q_full_i;
  assign in_stall_o  = !adv;
  assign push_o      = tail_vld_q && !q_full_i;
  assign push_item_o = tail_q;

  // Fold the left half plane over so the rotation converges
  always_comb begin
    re_pre  = CORDIC_W'(target_z_i) <<< CORDIC_FRAC;
    im_pre  = CORDIC_W'(target_x_i) <<< CORDIC_FRAC;
    acc_pre = '0;
    org_pre = (target_x_i == '0) && (target_z_i == '0);
    if (target_z_i[COORD_W-1]) begin
      re_pre  = -re_pre;
      im_pre  = -im_pre;
      acc_pre = ACC_HALF;
    end
  end

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      if (!im_q[i][CORDIC_W-1] && (im_q[i] != '0)) begin
        re_nx[i]  = re_q[i] + (im_q[i] >>> i);
        im_nx[i]  = im_q[i] - (re_q[i] >>> i);
        acc_nx[i] = acc_q[i] + atan_lut(5'(i));
      end else begin
        re_nx[i]  = re_q[i] - (im_q[i] >>> i);
        im_nx[i]  = im_q[i] + (re_q[i] >>> i);
        acc_nx[i] = acc_q[i] - atan_lut(5'(i));
      end
    end
  end

  // Round the turn fraction, clamp around the rest bearing, saturate the step
  always_comb begin
    rounded = {acc_q[NS], 1'b0} + ((ACC_W + 1)'(1) << RND_SHIFT);
    bearing = org_q[NS] ? '0 : rounded[ACC_W -: ANGLE_BITS];
    rest_a  = rest_angle(cfg_i.rest_bearing);
    lim     = signed'(OFF_W'(cfg_i.arc_half));
    off     = clamp_sym(shortest_turn(rest_a, bearing), lim);
    prod_w  = SAT_W'(prod_q[NS]);
    half_w  = SAT_W'(1) << (ANGLE_BITS - 1);

    fin.op      = op_q[NS];
    fin.goal    = rest_a + ANGLE_BITS'(off);
    fin.hold    = hold_q[NS];
    fin.elapsed = el_q[NS];
    fin.step    = (prod_w > half_w) ? ANGLE_BITS'(half_w) : ANGLE_BITS'(prod_w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      tail_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q      <= {vld_q[NS-1:0], in_valid_i};
      tail_vld_q <= vld_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      re_q[0]   <= re_pre;
      im_q[0]   <= im_pre;
      acc_q[0]  <= acc_pre;
      org_q[0]  <= org_pre;
      op_q[0]   <= op_e'(operation_i);
      hold_q[0] <= hold_time_i;
      el_q[0]   <= elapsed_i;
      prod_q[0] <= PROD_W'(cfg_i.traverse_rate) * PROD_W'(elapsed_i);
      for (int i = 0; i < NS; i++) begin
        re_q[i+1]   <= re_nx[i];
        im_q[i+1]   <= im_nx[i];
        acc_q[i+1]  <= acc_nx[i];
        org_q[i+1]  <= org_q[i];
        op_q[i+1]   <= op_q[i];
        hold_q[i+1] <= hold_q[i];
        el_q[i+1]   <= el_q[i];
        prod_q[i+1] <= prod_q[i];
      end
      tail_q <= fin;
    end
  end

endmodule
`default_nettype wire

@@ design/tasc_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Turret aim item queue
// Short first-in first-out buffer decoupling the front end from the back end.
// ----------------------------------------------------------------------------
module tasc_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire tasc_pkg::tasc_item_t push_item_i,
  output logic                      full_o,
  output logic                      valid_o,
  output tasc_pkg::tasc_item_t      head_o,
  input  wire logic                 pop_i
);
  import tasc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  tasc_item_t       mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule
`default_nettype wire

@@ design/tasc_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Turret aim slew back end
// Applies queued items to the aim, goal and hold state and registers the
// result transaction.
// ----------------------------------------------------------------------------
module tasc_back (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire tasc_pkg::tasc_cfg_t      cfg_i,
  input  wire logic                     q_valid_i,
  input  wire tasc_pkg::tasc_item_t     q_head_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic signed [15:0]            aim_angle_o,
  output logic signed [15:0]            goal_angle_o,
  output logic                          holding_o
);
  import tasc_pkg::*;

  angle_t            aim_q, aim_d;
  angle_t            goal_q, goal_d;
  logic [HOLD_W-1:0] hold_q, hold_d;
  angle_t            target;
  offset_t           dlt;

  logic              out_vld_q;
  angle_t            out_aim_q;
  angle_t            out_goal_q;
  logic              out_hold_q;

  assign pop_o        = q_valid_i && (!out_vld_q || !out_stall_i);
  assign out_valid_o  = out_vld_q;
  assign aim_angle_o  = OUT_W'(out_aim_q);
  assign goal_angle_o = OUT_W'(out_goal_q);
  assign holding_o    = out_hold_q;

  always_comb begin
    aim_d  = aim_q;
    goal_d = goal_q;
    hold_d = hold_q;
    target = '0;
    dlt    = '0;
    case (q_head_i.op)
      OP_AIM: begin
        goal_d = q_head_i.goal;
        hold_d = q_head_i.hold;
      end
      default: begin
        // Count the hold down first, then steer toward goal or stow
        hold_d = (hold_q > HOLD_W'(q_head_i.elapsed)) ?
                 hold_q - HOLD_W'(q_head_i.elapsed) : '0;
        target = (hold_d != '0) ? goal_q : rest_angle(cfg_i.rest_bearing);
        dlt    = clamp_sym(shortest_turn(aim_q, target), signed'(OFF_W'(q_head_i.step)));
        aim_d  = aim_q + ANGLE_BITS'(dlt);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aim_q     <= '0;
      goal_q    <= '0;
      hold_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (pop_o) begin
        aim_q     <= aim_d;
        goal_q    <= goal_d;
        hold_q    <= hold_d;
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_aim_q  <= aim_d;
      out_goal_q <= goal_d;
      out_hold_q <= (hold_d != '0);
    end
  end

endmodule
`default_nettype wire

@@ design/turret_aim_slew_controller_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Turret aim slew controller
// Bearing from a target point by CORDIC, arc clamp, hold timer and
// rate-limited slew of the turret aim in binary angle units.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries aim or tick transactions;
//   output channel (out_valid_o / out_stall_i) returns one result per item
//   with the aim, the goal and the holding flag after that item.
//   Configuration writes arrive on cfg_valid_i / cfg_ready_o with an index
//   and data; ready is always high. Write registers only while idle.
//   Path: a taken item passes through 1 entry stage, 16 CORDIC stages,
//   1 clamp stage, the queue and the output register before its result is shown.
//   Throughput: one item per cycle while neither channel stalls; the CORDIC
//   pipeline and the back end state update each advance one item per clock.
//   A stalled receiver holds the output register; the back end then stops
//   popping, the queue fills, and only then does in_stall_o rise.
//   Reset clears the aim, goal and hold state to zero, the rest bearing to
//   zero, the arc half to full range and the traverse rate to zero.
// ----------------------------------------------------------------------------
module turret_aim_slew_controller_top (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [tasc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [tasc_pkg::CFG_DAT_W-1:0]      cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic                                operation_i,
  input  wire logic signed [15:0]                  target_x_i,
  input  wire logic signed [15:0]                  target_z_i,
  input  wire logic [15:0]                         hold_time_i,
  input  wire logic [9:0]                          elapsed_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [15:0]                       aim_angle_o,
  output logic signed [15:0]                       goal_angle_o,
  output logic                                     holding_o
);
  import tasc_pkg::*;

  tasc_cfg_t  cfg_q, cfg_d;
  logic       q_full;
  logic       q_valid;
  logic       push;
  logic       pop;
  tasc_item_t push_item;
  tasc_item_t q_head;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_REST_BEARING:  cfg_d.rest_bearing  = signed'(REST_W'(cfg_data_i));
        CFG_ARC_HALF:      cfg_d.arc_half      = cfg_data_i[ARC_W-1:0];
        CFG_TRAVERSE_RATE: cfg_d.traverse_rate = cfg_data_i[RATE_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rest_bearing  <= '0;
      cfg_q.arc_half      <= '1;
      cfg_q.traverse_rate <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tasc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .target_x_i  (target_x_i),
    .target_z_i  (target_z_i),
    .hold_time_i (hold_time_i),
    .elapsed_i   (elapsed_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_item_o (push_item)
  );

  tasc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .head_o      (q_head),
    .pop_i       (pop)
  );

  tasc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_valid_i    (q_valid),
    .q_head_i     (q_head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .aim_angle_o  (aim_angle_o),
    .goal_angle_o (goal_angle_o),
    .holding_o    (holding_o)
  );

endmodule
`default_nettype wire

@@ tb/turret_aim_slew_controller_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Turret aim slew controller testbench
// Drives aim and tick transactions with random idling on both channels and
// predicts each aim, goal and holding result from an independent CORDIC,
// arc clamp, hold countdown and rate-limited slew model.
// ----------------------------------------------------------------------------
module turret_aim_slew_controller_top_tb;
  import tasc_pkg::*;

  localparam int CLK_PERIOD      = 10;
  localparam int TIMEOUT_NS      = 2_000_000;
  localparam int SETTLE_CYCLES   = 25;
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int REPORT_LIMIT    = 10;
  localparam int ROUND_SH        = 32 - ANGLE_BITS;
  localparam int PHASE_ITEMS     = 230;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  // atan(2^-k) as a turn fraction scaled by 2^32, entry 0 in the top word
  localparam logic [32*32-1:0] ATAN_TURN = {
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000};

  typedef struct {
    logic [15:0] aim;
    logic [15:0] goal;
    logic        holding;
  } aim_result_t;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 cfg_valid_i  = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i  = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i   = '0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_stall_o;
  logic                 operation_i  = 1'b0;
  logic signed [15:0]   target_x_i   = '0;
  logic signed [15:0]   target_z_i   = '0;
  logic [15:0]          hold_time_i  = '0;
  logic [9:0]           elapsed_i    = '0;
  logic                 out_valid_o;
  logic                 out_stall_i  = 1'b0;
  logic signed [15:0]   aim_angle_o;
  logic signed [15:0]   goal_angle_o;
  logic                 holding_o;

  // Shadow registers and slew state
  logic [15:0] cfg_rest = 16'h0000;
  logic [14:0] cfg_arc  = 15'h7FFF;
  logic [11:0] cfg_rate = 12'h000;
  logic [15:0] mdl_aim  = '0;
  logic [15:0] mdl_goal = '0;
  logic [15:0] mdl_hold = '0;

  aim_result_t expected_aims[$];
  int          fail_count      = 0;
  int          sender_idle_pct = 19;
  int          recv_stall_pct  = 19;
  int          hold_off_asked  = 0;
  int          hold_off_seen   = 0;
  int          hold_off_left   = 0;

  turret_aim_slew_controller_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .target_x_i   (target_x_i),
    .target_z_i   (target_z_i),
    .hold_time_i  (hold_time_i),
    .elapsed_i    (elapsed_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .aim_angle_o  (aim_angle_o),
    .goal_angle_o (goal_angle_o),
    .holding_o    (holding_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Bearing of (x, z) as a turn fraction, rotated towards the positive z axis
  function automatic logic [15:0] cordic_bearing(input logic signed [15:0] x,
                                                 input logic signed [15:0] z);
    longint      re;
    longint      im;
    longint      nre;
    logic [31:0] acc;
    int          k;
    acc = '0;
    if (x == 0 && z == 0) begin
      return '0;
    end
    re = longint'(z) * 65536;
    im = longint'(x) * 65536;
    if (re < 0) begin
      re  = -re;
      im  = -im;
      acc = 32'h8000_0000;
    end
    for (k = 0; k < CORDIC_STEPS; k++) begin
      if (im > 0) begin
        nre = re + (im >>> (k % 32));
        im  = im - (re >>> (k % 32));
        acc = acc + ATAN_TURN[(31 - (k % 32)) * 32 +: 32];
      end else begin
        nre = re - (im >>> (k % 32));
        im  = im + (re >>> (k % 32));
        acc = acc - ATAN_TURN[(31 - (k % 32)) * 32 +: 32];
      end
      re = nre;
    end
    acc = acc + (32'd1 << (ROUND_SH - 1));
    return 16'(acc >> ROUND_SH);
  endfunction

  // Signed shortest way round, half a turn taken as positive
  function automatic int turn_offset(input logic [15:0] from_a, input logic [15:0] to_a);
    logic [15:0] d;
    int          s;
    d = to_a - from_a;
    s = (d >= 16'h8000) ? int'(d) - 65536 : int'(d);
    if (s == -32768) begin
      s = 32768;
    end
    return s;
  endfunction

  task automatic slew_predict(input op_e op, input logic [15:0] x, input logic [15:0] z,
                              input logic [15:0] hold, input logic [9:0] el);
    int          off;
    int          lim;
    int          step;
    logic [15:0] target;
    aim_result_t res;
    if (op == OP_AIM) begin
      off = turn_offset(cfg_rest, cordic_bearing(x, z));
      lim = int'(cfg_arc);
      if (off > lim) off = lim;
      if (off < -lim) off = -lim;
      mdl_goal = cfg_rest + 16'(off);
      mdl_hold = hold;
    end else begin
      mdl_hold = (mdl_hold > el) ? mdl_hold - el : '0;
      target   = (mdl_hold != '0) ? mdl_goal : cfg_rest;
      step     = int'(cfg_rate) * int'(el);
      if (step > 32768) step = 32768;
      if (step != 0) begin
        off = turn_offset(mdl_aim, target);
        if (off > step) off = step;
        if (off < -step) off = -step;
        mdl_aim = mdl_aim + 16'(off);
      end
    end
    res.aim     = mdl_aim;
    res.goal    = mdl_goal;
    res.holding = (mdl_hold != '0);
    expected_aims.insert(expected_aims.size(), res);
  endtask

  task automatic send_item(input op_e op, input logic [15:0] x, input logic [15:0] z,
                           input logic [15:0] hold, input logic [9:0] el);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    target_x_i  <= x;
    target_z_i  <= z;
    hold_time_i <= hold;
    elapsed_i   <= el;
    do @(posedge clk_i); while (in_stall_o);
    slew_predict(op, x, z, hold, el);
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_aims.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_REST_BEARING:  cfg_rest = data;
      CFG_ARC_HALF:      cfg_arc  = data[14:0];
      CFG_TRAVERSE_RATE: cfg_rate = data[11:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [15:0] rest, input logic [15:0] arc,
                                input logic [15:0] rate);
    write_register(CFG_REST_BEARING, rest);
    write_register(CFG_ARC_HALF, arc);
    write_register(CFG_TRAVERSE_RATE, rate);
  endtask

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(3))
      0:       return 16'($urandom_range(128)) - 16'd64;
      1:       return $urandom_range(1) ? 16'h8000 : ($urandom_range(1) ? 16'h7FFF : 16'h0000);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_hold();
    return ($urandom_range(99) < 70) ? 16'($urandom_range(400)) : 16'($urandom);
  endfunction

  function automatic logic [9:0] pick_elapsed();
    case ($urandom_range(19))
      0, 1, 2:       return 10'($urandom_range(1023));
      3, 4, 5, 6, 7: return 10'($urandom_range(200));
      default:       return 10'($urandom_range(16));
    endcase
  endfunction

  // Mostly an aim followed by a burst of ticks; the rest is loose noise
  task automatic run_engagements(input int count);
    int sent;
    int ticks;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 85) begin
        send_item(OP_AIM, pick_coord(), pick_coord(), pick_hold(), 10'($urandom));
        ticks = $urandom_range(1, 6);
        sent += ticks + 1;
        repeat (ticks) begin
          send_item(OP_TICK, 16'($urandom), 16'($urandom), 16'($urandom), pick_elapsed());
        end
      end else begin
        send_item(op_e'($urandom_range(1)), 16'($urandom), 16'($urandom), 16'($urandom),
                  10'($urandom));
        sent++;
      end
    end
  endtask

  task automatic test_reset_state();
    send_item(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 10'd0);
    send_item(OP_AIM,  16'h0000, 16'h0000, 16'h0000, 10'd0);
    send_item(OP_AIM,  16'h7FFF, 16'h0000, 16'hFFFF, 10'd0);
    send_item(OP_AIM,  16'h8000, 16'h8000, 16'd3,    10'd0);
    send_item(OP_AIM,  16'h0000, 16'h8000, 16'd10,   10'h3FF);
    send_item(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 10'h3FF);
    send_item(OP_AIM,  16'h7FFF, 16'h7FFF, 16'hFFFF, 10'd0);
    send_item(OP_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'd1);
    wait_for_results();
  endtask

  task automatic test_register_extremes();
    apply_settings(16'h8000, 16'h0000, 16'h0FFF);
    write_register(CFG_SPARE_IDX, 16'hFFFF);
    send_item(OP_AIM,  16'hFFFF, 16'h7FFF, 16'd1023, 10'd0);
    send_item(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 10'h3FF);
    send_item(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 10'd0);
    wait_for_results();
    apply_settings(16'h7FFF, 16'hFFFF, 16'hF001);
    send_item(OP_AIM,  16'd12345, 16'hB1E0, 16'd500, 10'd0);
    send_item(OP_TICK, 16'h0000,  16'h0000, 16'h0000, 10'h3FF);
    send_item(OP_TICK, 16'h0000,  16'h0000, 16'h0000, 10'd5);
    wait_for_results();
    apply_settings(16'h7FFF, 16'd1000, 16'h0FFF);
    send_item(OP_AIM,  16'h8000, 16'h0001, 16'hFFFF, 10'd0);
    send_item(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 10'd8);
    send_item(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 10'd9);
    wait_for_results();
  endtask

  // Sender stops mid-stream until the pipeline has fully drained
  task automatic test_input_pause();
    apply_settings(16'($urandom), 16'($urandom_range(4000)), 16'($urandom_range(1, 50)));
    run_engagements(40);
    wait_for_results();
    run_engagements(40);
    wait_for_results();
  endtask

  // Hold the receiver off so the queue fills and the input stalls
  task automatic test_output_backpressure();
    apply_settings(16'($urandom), 16'h7FFF, 16'd200);
    sender_idle_pct = 0;
    hold_off_asked++;
    run_engagements(80);
    wait_for_results();
    sender_idle_pct = 19;
  endtask

  task automatic test_random_sweep();
    int phase;
    for (phase = 0; phase < 7; phase++) begin
      case (phase)
        0: apply_settings(16'h0000, 16'h7FFF, 16'd64);
        1: apply_settings(16'h8000, 16'h0000, 16'h0FFF);
        2: apply_settings(16'h7FFF, 16'h7FFF, 16'd1);
        3: apply_settings(16'($urandom), 16'($urandom), 16'($urandom_range(1, 40)));
        4: apply_settings(16'($urandom), 16'($urandom_range(2000)), 16'($urandom));
        5: apply_settings(16'($urandom), 16'($urandom), 16'h0000);
        default: apply_settings(16'($urandom), 16'($urandom), 16'($urandom_range(1, 300)));
      endcase
      if (phase == 4) write_register(CFG_SPARE_IDX, 16'($urandom));
      // last phase runs flat out on both sides
      sender_idle_pct = (phase == 6) ? 0 : 19;
      recv_stall_pct  = (phase == 6) ? 0 : 19;
      run_engagements(PHASE_ITEMS);
      wait_for_results();
    end
    sender_idle_pct = 19;
    recv_stall_pct  = 19;
  endtask

  always @(posedge clk_i) begin
    aim_result_t want;
    if (out_valid_o && !out_stall_i) begin
      if (expected_aims.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("%0t: unexpected transaction aim %h goal %h holding %b",
                   $time, aim_angle_o, goal_angle_o, holding_o);
      end else begin
        want = expected_aims.pop_front();
        if (aim_angle_o !== want.aim || goal_angle_o !== want.goal ||
            holding_o !== want.holding) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("%0t: expected aim %h goal %h holding %b, got aim %h goal %h holding %b",
                     $time, want.aim, want.goal, want.holding,
                     aim_angle_o, goal_angle_o, holding_o);
        end
      end
    end
    if (hold_off_seen != hold_off_asked) begin
      hold_off_seen = hold_off_asked;
      hold_off_left = HOLD_OFF_CYCLES;
    end
    if (hold_off_left > 0) begin
      hold_off_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_register_extremes();
    test_input_pause();
    test_output_backpressure();
    test_random_sweep();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && expected_aims.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ sim.f @@
design/tasc_pkg.sv
design/tasc_front.sv
design/tasc_queue.sv
design/tasc_back.sv
design/turret_aim_slew_controller_top.sv
tb/turret_aim_slew_controller_top_tb.sv
